@@ sv/bmsfs_pkg.sv @@
// Package for the battery monitor frame sync decoder.
// Holds frame constants, the captured-frame struct and the framer status struct; no dependencies.
package bmsfs_pkg;

   localparam logic [7:0] SYNC_R    = 8'h52;
   localparam logic [7:0] SYNC_E    = 8'h45;
   localparam logic [7:0] SYNC_C    = 8'h43;
   localparam logic [7:0] SIGN_NEG  = 8'h01;
   localparam int         FRAME_LEN = 13;
   localparam int         POS_W     = 4;

   localparam logic [POS_W-1:0] POS_START = POS_W'(0);
   localparam logic [POS_W-1:0] POS_E     = POS_W'(1);
   localparam logic [POS_W-1:0] POS_C     = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

   typedef struct packed {
      logic [15:0] volt;
      logic [7:0]  sign;
      logic [15:0] amps;
      logic [15:0] ampmin;
      logic [7:0]  soc;
      logic [7:0]  err;
      logic [7:0]  temp;
   } frame_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             at_last;
   } framer_status_type;

endpackage

@@ sv/bmsfs_framer.sv @@
// Frame tracker: byte position counter, preamble check and payload capture.
// Depends on bmsfs_pkg.
module bmsfs_framer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_valid,
   input  logic [7:0]                   rx_byte,
   output logic                         frame_done,
   output bmsfs_pkg::frame_type         frame,
   output bmsfs_pkg::framer_status_type status
);
   import bmsfs_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pos_eff;
   logic [7:0]       bytes_ff [3:11];

   assign pos_eff = (pos_ff > POS_LAST) ? POS_START : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (byte_valid) begin
         case (pos_eff)
            POS_START: pos_in = (rx_byte == SYNC_R) ? POS_E : POS_START;
            POS_E:     pos_in = (rx_byte == SYNC_E) ? POS_C : POS_START;
            POS_C:     pos_in = (rx_byte == SYNC_C) ? POS_W'(3) : POS_START;
            POS_LAST:  pos_in = POS_START;
            default:   pos_in = pos_eff + POS_W'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_START;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 3; i <= 11; i++) begin
         if (byte_valid && pos_eff == POS_W'(i)) begin
            bytes_ff[i] <= rx_byte;
         end
      end
   end

   assign frame_done   = byte_valid && (pos_eff == POS_LAST);
   assign frame.volt   = {bytes_ff[4], bytes_ff[3]};
   assign frame.sign   = bytes_ff[5];
   assign frame.amps   = {bytes_ff[7], bytes_ff[6]};
   assign frame.ampmin = {bytes_ff[9], bytes_ff[8]};
   assign frame.soc    = bytes_ff[10];
   assign frame.err    = bytes_ff[11];
   assign frame.temp   = rx_byte;

   assign status.position = pos_ff;
   assign status.at_last  = (pos_eff == POS_LAST);

endmodule

@@ sv/bmsfs_decode.sv @@
// Field decode and result register: signs current, scales charge, holds the result.
// Depends on bmsfs_pkg.
module bmsfs_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_done,
   input  bmsfs_pkg::frame_type frame,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          voltage_decivolts,
   output logic signed [16:0]   current_deciamps,
   output logic signed [22:0]   discharged_coulombs,
   output logic [7:0]           soc_percent,
   output logic [7:0]           error_flags,
   output logic [7:0]           temperature_c
);
   import bmsfs_pkg::*;

   logic               valid_ff;
   logic [15:0]        volt_ff;
   logic signed [16:0] amps_ff, amps_in;
   logic signed [22:0] coul_ff, coul_in;
   logic [7:0]         soc_ff, err_ff, temp_ff;
   logic [22:0]        ampmin_ext, times60;

   always_comb begin
      amps_in = (frame.sign == SIGN_NEG) ? -$signed({1'b0, frame.amps})
                                         :  $signed({1'b0, frame.amps});
      ampmin_ext = {7'b0, frame.ampmin};
      times60    = (ampmin_ext << 6) - (ampmin_ext << 2);
      coul_in    = -$signed(times60);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frame_done) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         volt_ff <= frame.volt;
         amps_ff <= amps_in;
         coul_ff <= coul_in;
         soc_ff  <= frame.soc;
         err_ff  <= frame.err;
         temp_ff <= frame.temp;
      end
   end

   assign rsp_valid           = valid_ff;
   assign voltage_decivolts   = volt_ff;
   assign current_deciamps    = amps_ff;
   assign discharged_coulombs = coul_ff;
   assign soc_percent         = soc_ff;
   assign error_flags         = err_ff;
   assign temperature_c       = temp_ff;

endmodule

@@ sv/bms_frame_sync_decoder.sv @@
// Top level of the battery monitor frame sync decoder.
// rsp_valid rises in the cycle after the request carrying the last frame byte is accepted.
// Throughput: one request per cycle; only a last frame byte waits on a full result.
// Reset clears the byte position and the result valid; captured bytes are not reset.
// Depends on bmsfs_pkg, bmsfs_framer and bmsfs_decode.
module bms_frame_sync_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_voltage_decivolts,
   output logic signed [16:0]  rsp_current_deciamps,
   output logic signed [22:0]  rsp_discharged_coulombs,
   output logic [7:0]          rsp_soc_percent,
   output logic [7:0]          rsp_error_flags,
   output logic [7:0]          rsp_temperature_c
);
   import bmsfs_pkg::*;

   logic              accept;
   logic              frame_done;
   frame_type         frame;
   framer_status_type status;

   assign req_ready = !status.at_last || !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   bmsfs_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .rx_byte    (req_rx_byte),
      .frame_done (frame_done),
      .frame      (frame),
      .status     (status)
   );

   bmsfs_decode u_decode (
      .clock               (clock),
      .reset               (reset),
      .frame_done          (frame_done),
      .frame               (frame),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .voltage_decivolts   (rsp_voltage_decivolts),
      .current_deciamps    (rsp_current_deciamps),
      .discharged_coulombs (rsp_discharged_coulombs),
      .soc_percent         (rsp_soc_percent),
      .error_flags         (rsp_error_flags),
      .temperature_c       (rsp_temperature_c)
   );

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      status.position <= POS_LAST)
      else $error("byte position out of range");

   a_done_room: assert property (@(posedge clock) disable iff (reset)
      frame_done |-> (!rsp_valid || rsp_ready))
      else $error("frame completed with result register full");

   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> rsp_valid)
      else $error("completed frame produced no result");

   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (status.position == POS_START))
      else $error("position not restarted after frame");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for bms_frame_sync_decoder: serial bytes go in, decoded frames come out.
// Tracks frame sync and decode on its own and compares every result field by field.
// Depends on bmsfs_pkg and the bms_frame_sync_decoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bmsfs_pkg::*;

   typedef struct {
      logic        [15:0] voltage_decivolts;
      logic signed [16:0] current_deciamps;
      logic signed [22:0] discharged_coulombs;
      logic        [7:0]  soc_percent;
      logic        [7:0]  error_flags;
      logic        [7:0]  temperature_c;
   } decoded_frame_type;

   localparam int RANDOM_BYTES = 1650;
   localparam int HOLD_CYCLES  = 400;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic [15:0]        rsp_voltage_decivolts;
   logic signed [16:0] rsp_current_deciamps;
   logic signed [22:0] rsp_discharged_coulombs;
   logic [7:0]         rsp_soc_percent;
   logic [7:0]         rsp_error_flags;
   logic [7:0]         rsp_temperature_c;

   logic [7:0]        serial_bytes[$];
   decoded_frame_type expected_frames[$];
   logic [7:0]        frame_store[FRAME_LEN];
   logic [3:0]        frame_pos = '0;
   int                total_bytes = 0;
   int                req_count = 0;
   int                frame_count = 0;
   int                fail_count = 0;
   int                hold_left = 0;
   bit                hold_done = 1'b0;

   bms_frame_sync_decoder u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_rx_byte             (req_rx_byte),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_voltage_decivolts   (rsp_voltage_decivolts),
      .rsp_current_deciamps    (rsp_current_deciamps),
      .rsp_discharged_coulombs (rsp_discharged_coulombs),
      .rsp_soc_percent         (rsp_soc_percent),
      .rsp_error_flags         (rsp_error_flags),
      .rsp_temperature_c       (rsp_temperature_c)
   );

   always #5ns clock = ~clock;

   function automatic int run_phase();
      if (total_bytes == 0) return 0;
      return (req_count * 3) / total_bytes;
   endfunction

   function automatic void track_byte(logic [7:0] rx);
      decoded_frame_type f;
      logic [16:0]       amps;
      logic [22:0]       ampmin;
      if (frame_pos == 0 && rx != SYNC_R) return;
      frame_store[frame_pos] = rx;
      frame_pos++;
      if ((frame_pos == 2 && rx != SYNC_E) || (frame_pos == 3 && rx != SYNC_C)) begin
         frame_pos = '0;
         return;
      end
      if (frame_pos < FRAME_LEN) return;
      frame_pos = '0;
      amps   = {1'b0, frame_store[7], frame_store[6]};
      ampmin = {7'd0, frame_store[9], frame_store[8]};
      f.voltage_decivolts   = {frame_store[4], frame_store[3]};
      f.current_deciamps    = (frame_store[5] == SIGN_NEG) ? 17'd0 - amps : amps;
      f.discharged_coulombs = 23'd0 - ampmin * 23'd60;
      f.soc_percent         = frame_store[10];
      f.error_flags         = frame_store[11];
      f.temperature_c       = frame_store[12];
      expected_frames.push_back(f);
   endfunction

   task automatic push_frame(logic [15:0] volt, logic [7:0] sign, logic [15:0] amps,
                             logic [15:0] ampmin, logic [7:0] soc, logic [7:0] err,
                             logic [7:0] temp, int keep = FRAME_LEN);
      logic [7:0] fb[FRAME_LEN];
      fb = '{SYNC_R, SYNC_E, SYNC_C, volt[7:0], volt[15:8], sign, amps[7:0], amps[15:8],
             ampmin[7:0], ampmin[15:8], soc, err, temp};
      for (int i = 0; i < keep; i++) serial_bytes.push_back(fb[i]);
   endtask

   task automatic check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_byte(req_rx_byte);
            req_count++;
         end
         if (!req_valid || req_ready) begin
            if (serial_bytes.size() != 0 &&
                $urandom_range(0, 99) >= (run_phase() == 0 ? 6 : run_phase() == 1 ? 76 : 0))
            begin
               req_valid   <= 1'b1;
               req_rx_byte <= serial_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      decoded_frame_type f;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            frame_count++;
            if (expected_frames.size() == 0) begin
               $error("frame result with no request pending: voltage %0d",
                      rsp_voltage_decivolts);
               fail_count++;
            end else begin
               f = expected_frames.pop_front();
               check_field("voltage_decivolts", 32'(f.voltage_decivolts),
                           32'(rsp_voltage_decivolts));
               check_field("current_deciamps", 32'(f.current_deciamps),
                           32'(rsp_current_deciamps));
               check_field("discharged_coulombs", 32'(f.discharged_coulombs),
                           32'(rsp_discharged_coulombs));
               check_field("soc_percent", 32'(f.soc_percent), 32'(rsp_soc_percent));
               check_field("error_flags", 32'(f.error_flags), 32'(rsp_error_flags));
               check_field("temperature_c", 32'(f.temperature_c), 32'(rsp_temperature_c));
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && total_bytes != 0 && req_count >= (total_bytes * 5) / 6) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >=
                         (run_phase() == 0 ? 76 : run_phase() == 1 ? 6 : 0);
         end
      end
   end

   initial begin
      int         n;
      int         roll;
      int         k;
      logic [7:0] b;

      serial_bytes.push_back(8'h00);
      serial_bytes.push_back(SYNC_R);
      serial_bytes.push_back(SYNC_R);
      serial_bytes.push_back(SYNC_R);
      serial_bytes.push_back(SYNC_E);
      serial_bytes.push_back(SYNC_R);
      push_frame(16'hFFFF, SIGN_NEG, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      push_frame(16'h0000, SIGN_NEG, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);

      n = serial_bytes.size();
      while (serial_bytes.size() < n + RANDOM_BYTES) begin
         roll = $urandom_range(0, 99);
         k    = $urandom_range(0, 3);
         b    = (k == 0) ? 8'h00 : (k == 1) ? SIGN_NEG : 8'($urandom_range(0, 255));
         if (roll < 75) begin
            push_frame(16'($urandom_range(0, 65535)), b, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (roll < 85) begin
            serial_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (roll < 95) begin
            serial_bytes.push_back(SYNC_R);
            b = 8'($urandom_range(0, 255));
            if (k[0]) begin
               serial_bytes.push_back(b == SYNC_E ? SYNC_R : b);
            end else begin
               serial_bytes.push_back(SYNC_E);
               serial_bytes.push_back(b == SYNC_C ? SYNC_R : b);
            end
         end else begin
            push_frame(16'($urandom_range(0, 65535)), b, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom_range(3, FRAME_LEN - 1));
         end
      end
      total_bytes = serial_bytes.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_count != total_bytes || expected_frames.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Sent %0d serial bytes, checked %0d decoded frames across three idling mixes",
               req_count, frame_count);
      $display("and one %0d-cycle result stall; %0d mismatches.", HOLD_CYCLES, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
